// File: hdl/html_entity_decoder_assert.svh
// Assertion macros shared by the checker of the HTML entity decoder.
// Depends on nothing; included by hed_checker.sv.
`ifndef HTML_ENTITY_DECODER_ASSERT_SVH
`define HTML_ENTITY_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HED_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HED_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/hed_pkg.sv
// Types, codes and constant tables of the HTML entity decoder.
// No dependencies; used by hed_core, html_entity_decoder and hed_checker.
package hed_pkg;

  localparam int MAX_RESULTS = 5;
  localparam int RES_CNT_W   = 3;
  localparam int FIFO_DEPTH  = 16;
  localparam int NAME_COUNT  = 13;
  localparam int NAME_MAX    = 5;
  localparam int NAME_BYTES_MAX = 3;

  localparam logic [20:0] CODE_LIMIT = 21'h10FFFF;
  localparam logic [20:0] SURR_LO    = 21'h00D800;
  localparam logic [20:0] SURR_HI    = 21'h00DFFF;

  localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF8_LEAD4 = 8'hF0;
  localparam logic [7:0] UTF8_CONT  = 8'h80;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF_LO = 8'h66;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  typedef enum logic [1:0] {
    PH_TEXT    = 2'd0,
    PH_ENTITY  = 2'd1,
    PH_DISCARD = 2'd2
  } hed_phase_e;

  typedef enum logic [2:0] {
    ERR_NONE         = 3'd0,
    ERR_UNTERMINATED = 3'd1,
    ERR_NUM_SYNTAX   = 3'd2,
    ERR_CODE_POINT   = 3'd3,
    ERR_UNKNOWN_NAME = 3'd4,
    ERR_CONTROL      = 3'd5
  } hed_err_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_string;
    hed_err_e   error_code;
  } hed_res_t;

  // All results caused by one input byte, in stream order from index 0.
  typedef struct packed {
    logic [RES_CNT_W-1:0]            count;
    hed_res_t [MAX_RESULTS-1:0]      res;
  } hed_batch_t;

  // Named entities, matched with case.
  localparam logic [7:0] NAME_CHR [NAME_COUNT][NAME_MAX] = '{
    '{"a", "m", "p", CH_NUL, CH_NUL},
    '{"l", "t", CH_NUL, CH_NUL, CH_NUL},
    '{"g", "t", CH_NUL, CH_NUL, CH_NUL},
    '{"q", "u", "o", "t", CH_NUL},
    '{"a", "p", "o", "s", CH_NUL},
    '{"n", "b", "s", "p", CH_NUL},
    '{"r", "e", "g", CH_NUL, CH_NUL},
    '{"t", "r", "a", "d", "e"},
    '{"c", "o", "p", "y", CH_NUL},
    '{"n", "d", "a", "s", "h"},
    '{"m", "d", "a", "s", "h"},
    '{"t", "i", "m", "e", "s"},
    '{"m", "i", "c", "r", "o"}
  };

  localparam logic [2:0] NAME_LEN [NAME_COUNT] = '{
    3'd3, 3'd2, 3'd2, 3'd4, 3'd4, 3'd4, 3'd3, 3'd5, 3'd4, 3'd5, 3'd5, 3'd5, 3'd5
  };

  // UTF-8 bytes of each named entity; nbsp decodes to a plain space.
  localparam logic [7:0] NAME_BYTES [NAME_COUNT][NAME_BYTES_MAX] = '{
    '{8'h26, 8'h00, 8'h00},
    '{8'h3C, 8'h00, 8'h00},
    '{8'h3E, 8'h00, 8'h00},
    '{8'h22, 8'h00, 8'h00},
    '{8'h27, 8'h00, 8'h00},
    '{8'h20, 8'h00, 8'h00},
    '{8'hC2, 8'hAE, 8'h00},
    '{8'hE2, 8'h84, 8'hA2},
    '{8'hC2, 8'hA9, 8'h00},
    '{8'hE2, 8'h80, 8'h93},
    '{8'hE2, 8'h80, 8'h94},
    '{8'hC3, 8'h97, 8'h00},
    '{8'hC2, 8'hB5, 8'h00}
  };

  localparam logic [2:0] NAME_NBYTES [NAME_COUNT] = '{
    3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd3, 3'd2, 3'd3, 3'd3, 3'd2, 3'd2
  };

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR) ||
           (c == CH_FF);
  endfunction

  function automatic logic is_ctrl(input logic [7:0] c);
    return (c < CH_SPACE) || (c == CH_DEL);
  endfunction

endpackage

// File: hdl/hed_core.sv
// Decode stage of the HTML entity decoder: entity key capture, numeric and
// named entity resolution, whitespace normalization and error handling.
// Depends on hed_pkg.
module hed_core #(
  parameter int MAX_ENTITY_SPAN = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [7:0]         in_byte_i,
  input  logic               in_last_i,
  output hed_pkg::hed_batch_t batch_o
);
  import hed_pkg::*;

  localparam int KEY_DEPTH = MAX_ENTITY_SPAN - 1;
  localparam int KL_W      = $clog2(MAX_ENTITY_SPAN);
  localparam int IDX_W     = $clog2(KEY_DEPTH);

  hed_phase_e       phase_q, phase_d;
  logic [KL_W-1:0]  key_length_q, key_length_d;
  logic             pending_space_q, pending_space_d;
  logic             emitted_any_q, emitted_any_d;
  logic [7:0]       key_store_q [KEY_DEPTH];

  // Numeric entity accumulated one key byte at a time.
  logic             num_mode_q, num_mode_d;
  logic             num_hex_q, num_hex_d;
  logic             num_digit_q, num_digit_d;
  logic             num_bad_q, num_bad_d;
  logic             code_overflow_q, code_overflow_d;
  logic [20:0]      code_value_q, code_value_d;

  logic             digit_ok;
  logic [3:0]       digit_val;
  logic [24:0]      acc;

  logic [7:0]       key_view [NAME_MAX];
  logic [NAME_COUNT-1:0] name_hit;
  logic [3:0][7:0]  name_dec;
  logic [2:0]       name_n;

  hed_err_e         num_err;
  logic [3:0][7:0]  utf_dec;
  logic [2:0]       utf_n;

  hed_err_e         fin_err;
  logic [3:0][7:0]  fin_dec;
  logic [2:0]       fin_n;

  hed_err_e         step_err;
  logic             do_emit, emit_space, emit_bytes;
  logic [3:0][7:0]  dec;
  logic [2:0]       dec_n;
  logic             key_we, key_full, open_amp, close_semi, ent_open, active;

  function automatic hed_res_t byte_res(input logic [7:0] b);
    hed_res_t r;
    r.out_byte      = b;
    r.byte_valid    = 1'b1;
    r.end_of_string = 1'b0;
    r.error_code    = ERR_NONE;
    return r;
  endfunction

  // Fixed-position view of the first key bytes for name matching.
  for (genvar j = 0; j < NAME_MAX; j++) begin : g_view
    if (j < KEY_DEPTH) begin : g_key
      assign key_view[j] = key_store_q[j];
    end else begin : g_pad
      assign key_view[j] = CH_NUL;
    end
  end

  always_comb begin
    name_hit = '0;
    name_dec = '0;
    name_n   = '0;
    for (int k = 0; k < NAME_COUNT; k++) begin
      name_hit[k] = (8'(key_length_q) == 8'(NAME_LEN[k]));
      for (int j = 0; j < NAME_MAX; j++) begin
        if ((3'(j) < NAME_LEN[k]) && (key_view[j] != NAME_CHR[k][j])) begin
          name_hit[k] = 1'b0;
        end
      end
    end
    for (int k = 0; k < NAME_COUNT; k++) begin
      if (name_hit[k]) begin
        name_n = name_n | NAME_NBYTES[k];
        for (int j = 0; j < NAME_BYTES_MAX; j++) begin
          name_dec[j] = name_dec[j] | NAME_BYTES[k][j];
        end
      end
    end
  end

  // Code point checks and UTF-8 encoding of the accumulated value.
  always_comb begin
    if (!num_digit_q || num_bad_q) begin
      num_err = ERR_NUM_SYNTAX;
    end else if (code_overflow_q || (code_value_q == '0) ||
                 ((code_value_q >= SURR_LO) && (code_value_q <= SURR_HI))) begin
      num_err = ERR_CODE_POINT;
    end else begin
      num_err = ERR_NONE;
    end

    utf_dec = '0;
    if (code_value_q < 21'h80) begin
      utf_n      = 3'd1;
      utf_dec[0] = code_value_q[7:0];
    end else if (code_value_q < 21'h800) begin
      utf_n      = 3'd2;
      utf_dec[0] = UTF8_LEAD2 | {3'b000, code_value_q[10:6]};
      utf_dec[1] = UTF8_CONT | {2'b00, code_value_q[5:0]};
    end else if (code_value_q < 21'h10000) begin
      utf_n      = 3'd3;
      utf_dec[0] = UTF8_LEAD3 | {4'b0000, code_value_q[15:12]};
      utf_dec[1] = UTF8_CONT | {2'b00, code_value_q[11:6]};
      utf_dec[2] = UTF8_CONT | {2'b00, code_value_q[5:0]};
    end else begin
      utf_n      = 3'd4;
      utf_dec[0] = UTF8_LEAD4 | {5'b00000, code_value_q[20:18]};
      utf_dec[1] = UTF8_CONT | {2'b00, code_value_q[17:12]};
      utf_dec[2] = UTF8_CONT | {2'b00, code_value_q[11:6]};
      utf_dec[3] = UTF8_CONT | {2'b00, code_value_q[5:0]};
    end
  end

  always_comb begin
    if ((key_length_q != '0) && num_mode_q) begin
      fin_err = num_err;
      fin_dec = utf_dec;
      fin_n   = utf_n;
    end else begin
      fin_err = (name_hit == '0) ? ERR_UNKNOWN_NAME : ERR_NONE;
      fin_dec = name_dec;
      fin_n   = name_n;
    end
  end

  // What the current byte does; shared by next state and results.
  always_comb begin
    step_err   = ERR_NONE;
    do_emit    = 1'b0;
    dec        = '0;
    dec_n      = '0;
    key_we     = 1'b0;
    open_amp   = 1'b0;
    close_semi = 1'b0;
    key_full   = (key_length_q >= KL_W'(KEY_DEPTH));
    if (in_valid_i) begin
      case (phase_q)
        PH_TEXT: begin
          if (in_byte_i == CH_AMP) begin
            open_amp = 1'b1;
          end else begin
            do_emit = 1'b1;
            dec[0]  = in_byte_i;
            dec_n   = 3'd1;
          end
        end
        PH_ENTITY: begin
          if (in_byte_i == CH_SEMI) begin
            close_semi = 1'b1;
            if (fin_err != ERR_NONE) begin
              step_err = fin_err;
            end else begin
              do_emit = 1'b1;
              dec     = fin_dec;
              dec_n   = fin_n;
            end
          end else if (key_full) begin
            step_err = ERR_UNTERMINATED;
          end else begin
            key_we = 1'b1;
          end
        end
        default: ;
      endcase
    end
    // Multi-byte sequences never start with a space or a control byte.
    emit_space = do_emit && (dec_n == 3'd1) && is_space(dec[0]);
    if (do_emit && !emit_space && is_ctrl(dec[0])) begin
      step_err = ERR_CONTROL;
    end
    ent_open = open_amp || (in_valid_i && (phase_q == PH_ENTITY) && !close_semi);
    if ((step_err == ERR_NONE) && in_last_i && ent_open) begin
      step_err = ERR_UNTERMINATED;
    end
    active     = in_valid_i && ((phase_q == PH_TEXT) || (phase_q == PH_ENTITY));
    emit_bytes = do_emit && !emit_space && (step_err == ERR_NONE);
  end

  // Next state.
  always_comb begin
    phase_d         = phase_q;
    key_length_d    = key_length_q;
    pending_space_d = pending_space_q;
    emitted_any_d   = emitted_any_q;
    if (active) begin
      if (open_amp) begin
        phase_d      = PH_ENTITY;
        key_length_d = '0;
      end
      if (close_semi) begin
        phase_d = PH_TEXT;
      end
      if (key_we) begin
        key_length_d = key_length_q + KL_W'(1);
      end
      if (emit_space) begin
        pending_space_d = pending_space_q | emitted_any_q;
      end
      if (emit_bytes) begin
        emitted_any_d   = 1'b1;
        pending_space_d = 1'b0;
      end
      if (step_err != ERR_NONE) begin
        phase_d = PH_DISCARD;
      end
    end
    if (in_valid_i && in_last_i) begin
      phase_d         = PH_TEXT;
      key_length_d    = '0;
      pending_space_d = 1'b0;
      emitted_any_d   = 1'b0;
    end
  end

  // Numeric key tracking, advanced as each key byte is stored.
  always_comb begin
    num_mode_d      = num_mode_q;
    num_hex_d       = num_hex_q;
    num_digit_d     = num_digit_q;
    num_bad_d       = num_bad_q;
    code_overflow_d = code_overflow_q;
    code_value_d    = code_value_q;
    digit_ok        = 1'b0;
    digit_val       = '0;
    if (in_byte_i inside {[CH_0:CH_9]}) begin
      digit_ok  = 1'b1;
      digit_val = in_byte_i[3:0];
    end else if (num_hex_q && (in_byte_i inside {[CH_LA:CH_LF_LO], [CH_UA:CH_UF]})) begin
      digit_ok  = 1'b1;
      digit_val = in_byte_i[3:0] + 4'd9;
    end
    if (num_hex_q) begin
      acc = {code_value_q, 4'h0} + {21'd0, digit_val};
    end else begin
      acc = {1'b0, code_value_q, 3'b000} + {3'b000, code_value_q, 1'b0} +
            {21'd0, digit_val};
    end
    if (key_we) begin
      if (key_length_q == '0) begin
        num_mode_d      = (in_byte_i == CH_HASH);
        num_hex_d       = 1'b0;
        num_digit_d     = 1'b0;
        num_bad_d       = 1'b0;
        code_overflow_d = 1'b0;
        code_value_d    = '0;
      end else if (num_mode_q) begin
        if ((key_length_q == KL_W'(1)) && ((in_byte_i == CH_LX) || (in_byte_i == CH_UX))) begin
          num_hex_d = 1'b1;
        end else if (!digit_ok) begin
          num_bad_d = 1'b1;
        end else begin
          num_digit_d = 1'b1;
          // Once past the limit the value is dead; the entity fails anyway.
          if (!code_overflow_q) begin
            if (acc > {4'd0, CODE_LIMIT}) begin
              code_overflow_d = 1'b1;
            end else begin
              code_value_d = acc[20:0];
            end
          end
        end
      end
    end
  end

  // Results of the current byte.
  always_comb begin
    batch_o = '0;
    if (active) begin
      if (step_err != ERR_NONE) begin
        batch_o.count                  = RES_CNT_W'(1);
        batch_o.res[0].end_of_string   = 1'b1;
        batch_o.res[0].error_code      = step_err;
      end else begin
        if (emit_bytes) begin
          if (pending_space_q) begin
            batch_o.res[0] = byte_res(CH_SPACE);
            for (int i = 0; i < 4; i++) begin
              if (3'(i) < dec_n) begin
                batch_o.res[i + 1] = byte_res(dec[i]);
              end
            end
            batch_o.count = dec_n + 3'd1;
          end else begin
            for (int i = 0; i < 4; i++) begin
              if (3'(i) < dec_n) begin
                batch_o.res[i] = byte_res(dec[i]);
              end
            end
            batch_o.count = dec_n;
          end
        end
        if (in_last_i) begin
          if (batch_o.count == '0) begin
            batch_o.count                = RES_CNT_W'(1);
            batch_o.res[0].end_of_string = 1'b1;
          end else begin
            batch_o.res[batch_o.count - RES_CNT_W'(1)].end_of_string = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_TEXT;
      key_length_q    <= '0;
      pending_space_q <= 1'b0;
      emitted_any_q   <= 1'b0;
      num_mode_q      <= 1'b0;
      num_hex_q       <= 1'b0;
      num_digit_q     <= 1'b0;
      num_bad_q       <= 1'b0;
      code_overflow_q <= 1'b0;
      code_value_q    <= '0;
    end else begin
      phase_q         <= phase_d;
      key_length_q    <= key_length_d;
      pending_space_q <= pending_space_d;
      emitted_any_q   <= emitted_any_d;
      num_mode_q      <= num_mode_d;
      num_hex_q       <= num_hex_d;
      num_digit_q     <= num_digit_d;
      num_bad_q       <= num_bad_d;
      code_overflow_q <= code_overflow_d;
      code_value_q    <= code_value_d;
    end
  end

  // Key bytes are only read below the current key length.
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_store_q[key_length_q[IDX_W-1:0]] <= in_byte_i;
    end
  end

endmodule

// File: hdl/html_entity_decoder.sv
// Top level of the HTML entity decoder: input register, decode stage and
// result queue. Depends on hed_pkg and hed_core.
//
// Channel   Side    Payload
// s_axis    input   tdata[7:0] text byte; tlast marks the string's last byte
// m_axis    output  tdata[7:0] byte, tdata[10:8] error code; tuser byte
//                   present; tlast end of string or error
//
// An accepted byte is decoded in the cycle after its transfer, and its
// results (zero to five) are offered from the cycle after that, one per cycle
// while the sink is ready. Input is taken every cycle while the result queue
// holds at most six results, so the sustained input rate is bounded by the
// output drain of one result per cycle. Reset clears control state and the
// queue; key bytes are not cleared. A stalled output holds off input once the
// queue holds more than six results.
module html_entity_decoder #(
  parameter int MAX_ENTITY_SPAN = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] out_byte, [10:8] error_code, zero above
  output logic        m_axis_tlast_o,
  output logic        m_axis_tuser_o    // [0] byte_valid
);
  import hed_pkg::*;

  localparam int PTR_W       = $clog2(FIFO_DEPTH);
  localparam int CNT_W       = PTR_W + 1;
  // Room for the byte in the input register and the one being accepted.
  localparam int READY_LIMIT = FIFO_DEPTH - 2 * MAX_RESULTS;

  logic             in_valid_q, in_valid_d;
  logic [7:0]       in_byte_q;
  logic             in_last_q;
  logic             in_xfer, out_xfer;
  hed_batch_t       batch;

  hed_res_t         fifo_mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  hed_res_t         head;

  assign s_axis_tready_o = (count_q <= CNT_W'(READY_LIMIT));
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign in_valid_d      = in_xfer;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  hed_core #(
    .MAX_ENTITY_SPAN(MAX_ENTITY_SPAN)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_q),
    .in_byte_i (in_byte_q),
    .in_last_i (in_last_q),
    .batch_o   (batch)
  );

  // Result queue: the whole batch of a byte is written at once.
  assign head            = fifo_mem[rd_ptr_q];
  assign m_axis_tvalid_o = (count_q != '0);
  assign m_axis_tdata_o  = {5'd0, head.error_code, head.out_byte};
  assign m_axis_tlast_o  = head.end_of_string;
  assign m_axis_tuser_o  = head.byte_valid;
  assign out_xfer        = m_axis_tvalid_o && m_axis_tready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q + PTR_W'(batch.count);
    rd_ptr_d = rd_ptr_q + PTR_W'(out_xfer);
    count_d  = count_q + CNT_W'(batch.count) - CNT_W'(out_xfer);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (RES_CNT_W'(i) < batch.count) begin
        fifo_mem[wr_ptr_q + PTR_W'(i)] <= batch.res[i];
      end
    end
  end

endmodule

// File: hdl/hed_checker.sv
// Port-level checks of the HTML entity decoder's result stream, bound to
// the top level. Depends on hed_pkg and html_entity_decoder_assert.svh.
`include "html_entity_decoder_assert.svh"

module hed_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_tvalid_i,
  input logic        m_tready_i,
  input logic [15:0] m_tdata_i,
  input logic        m_tlast_i,
  input logic        m_tuser_i
);
  import hed_pkg::*;

  // A result held back by the sink stays as it is.
  `HED_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_tvalid_i && !m_tready_i, m_tvalid_i && $stable(m_tdata_i) && $stable(m_tlast_i) && $stable(m_tuser_i), "output changed while stalled")

  // An error result carries no byte and closes the string.
  `HED_ASSERT_IMP(a_err_shape, clk_i, rst_ni, m_tvalid_i && (m_tdata_i[10:8] != ERR_NONE), m_tlast_i && !m_tuser_i && (m_tdata_i[7:0] == CH_NUL), "malformed error result")

  // Byte results are printable or UTF-8 bytes and carry no error code.
  `HED_ASSERT_IMP(a_byte_clean, clk_i, rst_ni, m_tvalid_i && m_tuser_i, (m_tdata_i[10:8] == ERR_NONE) && (m_tdata_i[7:0] >= CH_SPACE) && (m_tdata_i[7:0] != CH_DEL), "bad byte result")

  // Trailing whitespace is dropped, so a string never ends on a space.
  `HED_ASSERT_IMP(a_no_trailing_space, clk_i, rst_ni, m_tvalid_i && m_tuser_i && m_tlast_i, m_tdata_i[7:0] != CH_SPACE, "string ends in a space")

  // A collapsed space is queued together with the byte that follows it.
  `HED_ASSERT_NXT(a_space_then_byte, clk_i, rst_ni, m_tvalid_i && m_tready_i && m_tuser_i && (m_tdata_i[7:0] == CH_SPACE), m_tvalid_i && m_tuser_i && (m_tdata_i[7:0] != CH_SPACE), "space not followed by a byte")

endmodule

bind html_entity_decoder hed_checker u_hed_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .m_tvalid_i(m_axis_tvalid_o),
  .m_tready_i(m_axis_tready_i),
  .m_tdata_i (m_axis_tdata_o),
  .m_tlast_i (m_axis_tlast_o),
  .m_tuser_i (m_axis_tuser_o)
);
